// ----- sv/wmre_pkg.sv -----
// shared constants and control bundles for the windowed mean / rms / ema unit
// no dependencies
`default_nettype none

package wmre_pkg;

  localparam int unsigned SAMPLE_BITS_DEF     = 12;
  localparam int unsigned MAX_WINDOW_BITS_DEF = 10;

  // ema gain is unsigned q24, saturated at 1.0
  localparam int unsigned GAIN_FRAC = 24;
  localparam int unsigned GAIN_W    = GAIN_FRAC + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC{1'b0}}};

  localparam int unsigned CFG_DATA_W = GAIN_W;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMA_GAIN   = 2'd2;

  localparam int unsigned         WINDOW_LEN_RST = 200;
  localparam logic [GAIN_W-1:0]   EMA_GAIN_RST   = 25'd3355;

  typedef struct packed {
    logic div_start;
    logic root_start;
  } wmre_ctl_t;

  typedef struct packed {
    logic mean_busy;
    logic sq_busy;
    logic root_busy;
  } wmre_sts_t;

endpackage

`default_nettype wire

// ----- sv/windowed_mean_rms_ema_unit.sv -----
// top level of the windowed mean / rms / ema unit: config registers, front end,
// job queue, back end, two dividers and the square root unit
// depends on wmre_pkg, wmre_front, wmre_fifo, wmre_div, wmre_sqrt, wmre_back
//
//   port group   dir   contents
//   s_axis_*     in    tdata: raw_sample (low bits), zero padded to bytes
//   m_axis_*     out   tdata: mean, rms, ema (low to high); tuser: window_done
//   cfg_*        in    register write: 0 offset, 1 window_len, 2 ema_gain
//
// a sample passes the back end states idle, mul, acc and out; a sample that
// closes a window also waits in div on the 34-bit square-sum divider
// (2 quotient bits a cycle) and in root on the 12-step square root after it
// the two-entry job queue lets the input side run ahead while the back end
// works or the output register waits; reset clears counts, sums and the ema
`default_nettype none

module windowed_mean_rms_ema_unit #(
  parameter int unsigned MAX_WINDOW_BITS = wmre_pkg::MAX_WINDOW_BITS_DEF,
  parameter int unsigned SAMPLE_BITS     = wmre_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // raw_sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]              s_axis_tdata,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // mean, rms, ema
  output logic [((3*(SAMPLE_BITS+1)+7)/8)*8-1:0]        m_axis_tdata,
  // window_done
  output logic                                          m_axis_tuser,
  input  logic                                          cfg_we_i,
  input  logic [wmre_pkg::CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [wmre_pkg::CFG_DATA_W-1:0]               cfg_wdata_i
);

  import wmre_pkg::*;

  localparam int unsigned S          = SAMPLE_BITS;
  localparam int unsigned MWB        = MAX_WINDOW_BITS;
  localparam int unsigned OUT_W      = S + 1;
  localparam int unsigned OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;
  localparam int unsigned SUM_W      = S + MWB + 1;
  localparam int unsigned SQ_W       = 2 * S + MWB;
  localparam int unsigned JOB_W      = S + MWB + 2;

  logic [S-1:0]      offset_q, offset_d;
  logic [MWB-1:0]    window_len_q, window_len_d;
  logic [GAIN_W-1:0] ema_gain_q, ema_gain_d;

  always_comb begin
    offset_d     = offset_q;
    window_len_d = window_len_q;
    ema_gain_d   = ema_gain_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFFSET:     offset_d     = cfg_wdata_i[S-1:0];
        CFG_WINDOW_LEN: window_len_d = cfg_wdata_i[MWB-1:0];
        CFG_EMA_GAIN:   ema_gain_d   = cfg_wdata_i[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q     <= '0;
      window_len_q <= MWB'(WINDOW_LEN_RST);
      ema_gain_q   <= EMA_GAIN_RST;
    end else begin
      offset_q     <= offset_d;
      window_len_q <= window_len_d;
      ema_gain_q   <= ema_gain_d;
    end
  end

  logic             push, pop, q_full, q_empty;
  logic [JOB_W-1:0] job_in, job_out;

  wmre_front #(
    .SAMPLE_BITS     (S),
    .MAX_WINDOW_BITS (MWB)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_sample_i  (s_axis_tdata[S-1:0]),
    .offset_i     (offset_q),
    .window_len_i (window_len_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (job_in)
  );

  wmre_fifo #(
    .WIDTH (JOB_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (job_in),
    .pop_i   (pop),
    .dout_o  (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  wmre_ctl_t        ctl;
  wmre_sts_t        sts;
  logic [SUM_W-1:0] mean_num, mean_quo;
  logic [SQ_W-1:0]  sq_num, sq_quo;
  logic [MWB-1:0]   divisor;
  logic [2*S-1:0]   root_rad;
  logic [S-1:0]     root;
  logic [OUT_W-1:0] out_mean, out_rms, out_ema;

  wmre_div #(
    .DW (SUM_W),
    .VW (MWB)
  ) u_div_mean (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i (mean_num),
    .divisor_i  (divisor),
    .busy_o     (sts.mean_busy),
    .quot_o     (mean_quo)
  );

  wmre_div #(
    .DW (SQ_W),
    .VW (MWB)
  ) u_div_sq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i (sq_num),
    .divisor_i  (divisor),
    .busy_o     (sts.sq_busy),
    .quot_o     (sq_quo)
  );

  wmre_sqrt #(
    .RW (2 * S)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.root_start),
    .rad_i   (root_rad),
    .busy_o  (sts.root_busy),
    .root_o  (root)
  );

  wmre_back #(
    .SAMPLE_BITS     (S),
    .MAX_WINDOW_BITS (MWB)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .ema_gain_i  (ema_gain_q),
    .ctl_o       (ctl),
    .sts_i       (sts),
    .mean_num_o  (mean_num),
    .sq_num_o    (sq_num),
    .divisor_o   (divisor),
    .mean_quo_i  (mean_quo),
    .sq_quo_i    (sq_quo),
    .root_rad_o  (root_rad),
    .root_i      (root),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_mean_o  (out_mean),
    .out_rms_o   (out_rms),
    .out_ema_o   (out_ema),
    .out_done_o  (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_DATA_W'({out_ema, out_rms, out_mean});

  // dividers are only started when both are idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.div_start |-> !sts.mean_busy && !sts.sq_busy)
    else $error("divider started while busy");

  // a started division raises busy in both lanes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.div_start |=> sts.mean_busy && sts.sq_busy)
    else $error("divider did not start");

  // the root only starts once both quotients are final
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.root_start |-> !sts.mean_busy && !sts.sq_busy && !sts.root_busy)
    else $error("square root started early");

  // a root start always follows a division start and never overlaps it or a pop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.root_start |-> !ctl.div_start && !pop)
    else $error("root start overlaps another step");

endmodule

`default_nettype wire

// ----- sv/wmre_front.sv -----
// front end: takes samples, removes the offset, counts the window and
// marks the sample that closes it; depends on nothing outside this file
`default_nettype none

module wmre_front #(
  parameter int unsigned SAMPLE_BITS     = 12,
  parameter int unsigned MAX_WINDOW_BITS = 10
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0]                 in_sample_i,
  input  logic [SAMPLE_BITS-1:0]                 offset_i,
  input  logic [MAX_WINDOW_BITS-1:0]             window_len_i,
  input  logic                                   q_full_i,
  output logic                                   push_o,
  // job word, from bit 0: x, close flag, sample count
  output logic [SAMPLE_BITS+MAX_WINDOW_BITS+1:0] job_o
);

  localparam int unsigned XW = SAMPLE_BITS + 1;

  logic [MAX_WINDOW_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic                       close;
  logic                       accept;
  logic signed [XW-1:0]       x;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  assign x = $signed({1'b0, in_sample_i}) - $signed({1'b0, offset_i});

  always_comb begin
    cnt_inc = cnt_q + MAX_WINDOW_BITS'(1);
    // count saturates instead of wrapping
    if (cnt_inc == '0) begin
      cnt_inc = '1;
    end
    close = (cnt_inc >= window_len_i);
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = close ? '0 : cnt_inc;
    end
  end

  assign job_o = {cnt_inc, close, x};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/wmre_fifo.sv -----
// two-entry job queue between the front end and the back end
// no dependencies
`default_nettype none

module wmre_fifo #(
  parameter int unsigned WIDTH = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       level_q;

  assign full_o  = (level_q == 2'd2);
  assign empty_o = (level_q == 2'd0);
  assign dout_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + 2'd1;
      end else if (pop_i && !push_i) begin
        level_q <= level_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/wmre_div.sv -----
// unsigned restoring divider, two quotient bits per cycle
// no dependencies
`default_nettype none

module wmre_div #(
  parameter int unsigned DW = 34,
  parameter int unsigned VW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned PW    = DW + (DW % 2);
  localparam int unsigned STEPS = PW / 2;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic          busy_q;
  logic [CW-1:0] step_q;
  logic [VW-1:0] rem_q, rem_n;
  logic [PW-1:0] quo_q, quo_n;
  logic [VW-1:0] div_q;
  logic [VW:0]   r_ext, diff;
  logic          ge;

  always_comb begin
    rem_n = rem_q;
    quo_n = quo_q;
    r_ext = '0;
    diff  = '0;
    ge    = 1'b0;
    for (int i = 0; i < 2; i++) begin
      r_ext = {rem_n, quo_n[PW-1]};
      diff  = r_ext - {1'b0, div_q};
      ge    = (r_ext >= {1'b0, div_q});
      rem_n = ge ? diff[VW-1:0] : r_ext[VW-1:0];
      quo_n = {quo_n[PW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q[DW-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= PW'(dividend_i);
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= CW'(STEPS);
    end else if (busy_q) begin
      step_q <= step_q - CW'(1);
      if (step_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/wmre_sqrt.sv -----
// integer floor square root, one root bit per cycle
// no dependencies
`default_nettype none

module wmre_sqrt #(
  parameter int unsigned RW = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RW-1:0]   rad_i,
  output logic            busy_o,
  output logic [RW/2-1:0] root_o
);

  localparam int unsigned QW = RW / 2;
  localparam int unsigned CW = $clog2(QW + 1);

  logic          busy_q;
  logic [CW-1:0] step_q;
  logic [RW-1:0] rad_q;
  logic [QW+1:0] rem_q, rem_s, trial, rem_n;
  logic [QW-1:0] root_q, root_n;
  logic          ge;

  always_comb begin
    rem_s  = {rem_q[QW-1:0], rad_q[RW-1:RW-2]};
    trial  = {root_q, 2'b01};
    ge     = (rem_s >= trial);
    rem_n  = ge ? (rem_s - trial) : rem_s;
    root_n = {root_q[QW-2:0], ge};
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RW-3:0], 2'b00};
      rem_q  <= rem_n;
      root_q <= root_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= CW'(QW);
    end else if (busy_q) begin
      step_q <= step_q - CW'(1);
      if (step_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/wmre_back.sv -----
// back end: sums, ema update, window close sequencing and output register
// depends on wmre_pkg; drives the dividers and square root unit in the top
`default_nettype none

module wmre_back #(
  parameter int unsigned SAMPLE_BITS     = 12,
  parameter int unsigned MAX_WINDOW_BITS = 10
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic [SAMPLE_BITS+MAX_WINDOW_BITS+1:0]            job_i,
  input  logic                                              q_empty_i,
  output logic                                              pop_o,
  input  logic [wmre_pkg::GAIN_W-1:0]                       ema_gain_i,
  output wmre_pkg::wmre_ctl_t                               ctl_o,
  input  wmre_pkg::wmre_sts_t                               sts_i,
  output logic [SAMPLE_BITS+MAX_WINDOW_BITS:0]              mean_num_o,
  output logic [2*SAMPLE_BITS+MAX_WINDOW_BITS-1:0]          sq_num_o,
  output logic [MAX_WINDOW_BITS-1:0]                        divisor_o,
  input  logic [SAMPLE_BITS+MAX_WINDOW_BITS:0]              mean_quo_i,
  input  logic [2*SAMPLE_BITS+MAX_WINDOW_BITS-1:0]          sq_quo_i,
  output logic [2*SAMPLE_BITS-1:0]                          root_rad_o,
  input  logic [SAMPLE_BITS-1:0]                            root_i,
  output logic                                              out_valid_o,
  input  logic                                              out_ready_i,
  output logic [SAMPLE_BITS:0]                              out_mean_o,
  output logic [SAMPLE_BITS:0]                              out_rms_o,
  output logic [SAMPLE_BITS:0]                              out_ema_o,
  output logic                                              out_done_o
);

  import wmre_pkg::*;

  localparam int unsigned S      = SAMPLE_BITS;
  localparam int unsigned MWB    = MAX_WINDOW_BITS;
  localparam int unsigned XW     = S + 1;
  localparam int unsigned OUT_W  = S + 1;
  localparam int unsigned SUM_W  = S + MWB + 1;
  localparam int unsigned SQ_W   = 2 * S + MWB;
  localparam int unsigned EMA_W  = XW + GAIN_FRAC;
  localparam int unsigned D_W    = EMA_W + 1;
  localparam int unsigned DH_W   = D_W - GAIN_FRAC;
  localparam int unsigned P_HI_W = DH_W + GAIN_W + 1;
  localparam int unsigned P_LO_W = GAIN_FRAC + GAIN_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]               state_q, state_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [SQ_W-1:0]          sq_q, sq_d;
  logic signed [D_W-1:0]    d_q, d_d;
  logic signed [P_HI_W-1:0] p_hi_q, p_hi_d;
  logic [P_LO_W-1:0]        p_lo_q, p_lo_d;
  logic signed [EMA_W-1:0]  ema_q, ema_d;
  logic                     close_q, close_d;
  logic [MWB-1:0]           cnt_q, cnt_d;
  logic                     neg_q, neg_d;
  logic [OUT_W-1:0]         held_mean_q, held_mean_d;
  logic [OUT_W-1:0]         held_rms_q, held_rms_d;
  logic                     out_valid_q, out_valid_d;
  logic [OUT_W-1:0]         out_mean_q, out_mean_d;
  logic [OUT_W-1:0]         out_rms_q, out_rms_d;
  logic [OUT_W-1:0]         out_ema_q, out_ema_d;
  logic                     out_done_q, out_done_d;

  logic signed [XW-1:0]     job_x;
  logic                     job_close;
  logic [MWB-1:0]           job_cnt;
  logic signed [2*XW-1:0]   x_sq;
  logic signed [D_W-1:0]    x_sh;
  logic signed [DH_W-1:0]   dh;
  logic [GAIN_FRAC-1:0]     dl;
  logic [GAIN_W-1:0]        g_sat;
  logic signed [GAIN_W:0]   g_s;
  logic [SUM_W-1:0]         sum_u;
  logic [OUT_W-1:0]         mean_mag;
  logic [EMA_W-1:0]         ema_bias, ema_t;

  assign job_x     = job_i[XW-1:0];
  assign job_close = job_i[XW];
  assign job_cnt   = job_i[XW+1 +: MWB];

  assign x_sq  = job_x * job_x;
  assign x_sh  = D_W'(job_x) <<< GAIN_FRAC;
  // floor split of the difference keeps both products narrow
  assign dh    = d_q[D_W-1:GAIN_FRAC];
  assign dl    = d_q[GAIN_FRAC-1:0];
  assign g_sat = (ema_gain_i > GAIN_ONE) ? GAIN_ONE : ema_gain_i;
  assign g_s   = $signed({1'b0, g_sat});

  assign sum_u      = sum_q;
  assign mean_num_o = sum_u[SUM_W-1] ? (SUM_W'(0) - sum_u) : sum_u;
  assign sq_num_o   = sq_q;
  assign divisor_o  = cnt_q;
  assign root_rad_o = sq_quo_i[2*S-1:0];
  assign mean_mag   = {1'b0, mean_quo_i[S-1:0]};

  // truncate toward zero: bias negative values before the shift
  assign ema_bias = {{(EMA_W-GAIN_FRAC){1'b0}}, {GAIN_FRAC{ema_q[EMA_W-1]}}};
  assign ema_t    = ema_q + ema_bias;

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    sq_d        = sq_q;
    d_d         = d_q;
    p_hi_d      = p_hi_q;
    p_lo_d      = p_lo_q;
    ema_d       = ema_q;
    close_d     = close_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    held_mean_d = held_mean_q;
    held_rms_d  = held_rms_q;
    out_valid_d = out_valid_q;
    out_mean_d  = out_mean_q;
    out_rms_d   = out_rms_q;
    out_ema_d   = out_ema_q;
    out_done_d  = out_done_q;
    pop_o       = 1'b0;
    ctl_o       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          sum_d   = sum_q + SUM_W'(job_x);
          sq_d    = sq_q + SQ_W'(x_sq[2*S-1:0]);
          d_d     = x_sh - D_W'(ema_q);
          close_d = job_close;
          cnt_d   = job_cnt;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        p_hi_d  = dh * g_s;
        p_lo_d  = dl * g_sat;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        ema_d = ema_q + p_hi_q[EMA_W-1:0] + EMA_W'(p_lo_q[P_LO_W-1:GAIN_FRAC]);
        if (close_q) begin
          // dividers capture the sums on this edge
          ctl_o.div_start = 1'b1;
          neg_d           = sum_q[SUM_W-1];
          sum_d           = '0;
          sq_d            = '0;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (!sts_i.mean_busy && !sts_i.sq_busy) begin
          ctl_o.root_start = 1'b1;
          held_mean_d      = neg_q ? (OUT_W'(0) - mean_mag) : mean_mag;
          state_d          = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (!sts_i.root_busy) begin
          held_rms_d = {1'b0, root_i};
          state_d    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_mean_d  = held_mean_q;
          out_rms_d   = held_rms_q;
          out_ema_d   = ema_t[EMA_W-1:GAIN_FRAC];
          out_done_d  = close_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_mean_o  = out_mean_q;
  assign out_rms_o   = out_rms_q;
  assign out_ema_o   = out_ema_q;
  assign out_done_o  = out_done_q;

  always_ff @(posedge clk_i) begin
    d_q        <= d_d;
    p_hi_q     <= p_hi_d;
    p_lo_q     <= p_lo_d;
    close_q    <= close_d;
    cnt_q      <= cnt_d;
    neg_q      <= neg_d;
    out_mean_q <= out_mean_d;
    out_rms_q  <= out_rms_d;
    out_ema_q  <= out_ema_d;
    out_done_q <= out_done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      sq_q        <= '0;
      ema_q       <= '0;
      held_mean_q <= '0;
      held_rms_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      sq_q        <= sq_d;
      ema_q       <= ema_d;
      held_mean_q <= held_mean_d;
      held_rms_q  <= held_rms_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire
